/* rtl/core/rerd_pkg.sv */
// Shared types and constants for the raster escape run-length decoder.
// Used by the parser front end, the command queue, the run back end and the top level.
`default_nettype none

package rerd_pkg;

  localparam int NUMBER_BITS = 16;
  localparam int NUM_EXT     = NUMBER_BITS + 4;
  localparam int ROW_BITS    = 16;
  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);

  localparam logic [7:0] ESC_BYTE = 8'h1b;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_P = 8'h70;
  localparam logic [7:0] CH_UP_W  = 8'h57;
  localparam logic [7:0] CH_UP_M  = 8'h4d;
  localparam logic [7:0] CH_UP_Y  = 8'h59;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [9:0] ROW_WIDTH_RESET = 10'd80;
  localparam logic       REG_ROW_WIDTH   = 1'b0;

  localparam logic [1:0] KIND_RUN     = 2'd0;
  localparam logic [1:0] KIND_ROW_END = 2'd1;
  localparam logic [1:0] KIND_BLANK   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_STAR,
    PH_CMD,
    PH_DIGITS,
    PH_RASTER
  } parse_phase_t;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_ROW,
    CMD_MODE,
    CMD_SETROW
  } cmd_op_t;

  // flag: DATA = last byte of row, ROW = zero length, MODE = compression on
  typedef struct packed {
    cmd_op_t             op;
    logic [7:0]          data;
    logic [ROW_BITS-1:0] number;
    logic                flag;
  } cmd_t;

  typedef enum logic [1:0] {
    RUN_FRESH,
    RUN_HAVE,
    RUN_PAIR
  } run_phase_t;

  typedef enum logic {
    BK_MAIN,
    BK_ROW_END
  } back_step_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          pixel_byte;
    logic [ROW_BITS-1:0] run_count;
    logic [ROW_BITS-1:0] row_index;
    logic                last;
  } result_t;

  typedef struct packed {
    logic valid;
    cmd_t head;
  } cmdq_head_t;

endpackage

`default_nettype wire

/* rtl/core/rerd_front.sv */
// Parser front end: accepts stream bytes, tracks escape syntax and row length,
// and pushes classified commands into the queue. Depends on rerd_pkg.
`default_nettype none

module rerd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     stream_byte,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           q_full,
  output logic           cmd_push,
  output rerd_pkg::cmd_t cmd
);
  import rerd_pkg::*;

  parse_phase_t            phase;
  parse_phase_t            phase_next;
  logic                    is_raster;
  logic                    is_raster_next;
  logic [NUMBER_BITS-1:0]  number;
  logic [NUMBER_BITS-1:0]  number_next;
  logic [ROW_BITS-1:0]     remaining;
  logic [ROW_BITS-1:0]     remaining_next;

  logic                    accept;
  logic                    is_digit;
  logic [3:0]              digit_val;
  logic [7:0]              digit_diff;
  parse_phase_t            rescan_phase;
  logic [NUM_EXT-1:0]      num_mul;
  logic [NUMBER_BITS-1:0]  num_acc;
  logic [31:0]             num_wide;
  logic [ROW_BITS-1:0]     len16;

  assign in_ready     = !q_full;
  assign accept       = in_valid && !q_full;
  assign is_digit     = (stream_byte >= CH_ZERO) && (stream_byte <= CH_NINE);
  assign digit_diff   = stream_byte - CH_ZERO;
  assign digit_val    = digit_diff[3:0];
  assign rescan_phase = (stream_byte == ESC_BYTE) ? PH_ESC : PH_IDLE;
  assign num_mul      = NUM_EXT'(number) * NUM_EXT'(10) + NUM_EXT'(digit_val);
  assign num_acc      = (num_mul > NUM_EXT'({NUMBER_BITS{1'b1}})) ?
                        {NUMBER_BITS{1'b1}} : num_mul[NUMBER_BITS-1:0];
  assign num_wide     = 32'(number);
  assign len16        = (num_wide > 32'h0000_ffff) ? 16'hffff : num_wide[ROW_BITS-1:0];

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: phase_next = rescan_phase;
      PH_ESC: phase_next = (stream_byte == CH_STAR) ? PH_STAR : rescan_phase;
      PH_STAR: begin
        if (stream_byte == CH_LOW_B || stream_byte == CH_LOW_P) begin
          phase_next = PH_CMD;
        end else begin
          phase_next = rescan_phase;
        end
      end
      PH_CMD: phase_next = is_digit ? PH_DIGITS : rescan_phase;
      PH_DIGITS: begin
        priority if (is_digit) begin
          phase_next = PH_DIGITS;
        end else if (is_raster && stream_byte == CH_UP_W) begin
          phase_next = (len16 == '0) ? PH_IDLE : PH_RASTER;
        end else if (is_raster && stream_byte == CH_UP_M) begin
          phase_next = PH_IDLE;
        end else if (!is_raster && stream_byte == CH_UP_Y) begin
          phase_next = PH_IDLE;
        end else begin
          phase_next = rescan_phase;
        end
      end
      PH_RASTER: phase_next = (remaining == ROW_BITS'(1)) ? PH_IDLE : PH_RASTER;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    cmd_push       = 1'b0;
    cmd.op         = CMD_DATA;
    cmd.data       = stream_byte;
    cmd.number     = len16;
    cmd.flag       = 1'b0;
    is_raster_next = is_raster;
    number_next    = number;
    remaining_next = remaining;
    unique case (phase)
      PH_STAR: begin
        if (stream_byte == CH_LOW_B) begin
          is_raster_next = 1'b1;
        end else if (stream_byte == CH_LOW_P) begin
          is_raster_next = 1'b0;
        end
      end
      PH_CMD: begin
        if (is_digit) begin
          number_next = NUMBER_BITS'(digit_val);
        end
      end
      PH_DIGITS: begin
        priority if (is_digit) begin
          number_next = num_acc;
        end else if (is_raster && stream_byte == CH_UP_W) begin
          cmd_push       = accept;
          cmd.op         = CMD_ROW;
          cmd.flag       = (len16 == '0);
          remaining_next = len16;
        end else if (is_raster && stream_byte == CH_UP_M) begin
          cmd_push = accept;
          cmd.op   = CMD_MODE;
          cmd.flag = (number != '0);
        end else if (!is_raster && stream_byte == CH_UP_Y) begin
          cmd_push   = accept;
          cmd.op     = CMD_SETROW;
          cmd.number = num_wide[ROW_BITS-1:0];
        end else begin
          cmd_push = 1'b0;
        end
      end
      PH_RASTER: begin
        cmd_push       = accept;
        cmd.op         = CMD_DATA;
        cmd.flag       = (remaining == ROW_BITS'(1));
        remaining_next = remaining - ROW_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      is_raster <= 1'b0;
      number    <= '0;
      remaining <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      is_raster <= is_raster_next;
      number    <= number_next;
      remaining <= remaining_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rerd_cmdq.sv */
// Short command queue between parser and run back end.
// Register-based ring of rerd_pkg::cmd_t entries; depth from rerd_pkg.
`default_nettype none

module rerd_cmdq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rerd_pkg::cmd_t       push_data,
  output logic                 full,
  input  logic                 pop,
  output rerd_pkg::cmdq_head_t head
);
  import rerd_pkg::*;

  cmd_t               entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   count;
  logic               push_ok;
  logic               pop_ok;

  assign full       = (count == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign head.valid = (count != '0);
  assign head.head  = entries[rd_ptr];
  assign push_ok    = push && !full;
  assign pop_ok     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + CMDQ_AW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + CMDQ_AW'(1);
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + (CMDQ_AW + 1)'(1);
        2'b01:   count <= count - (CMDQ_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rerd_back.sv */
// Run back end: executes queued commands, expands compressed runs, pads rows,
// and drives the registered result beat. Depends on rerd_pkg.
`default_nettype none

module rerd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [9:0]           row_width,
  input  rerd_pkg::cmdq_head_t q,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rerd_pkg::result_t    result
);
  import rerd_pkg::*;

  back_step_t          step;
  back_step_t          step_next;
  logic                compression;
  logic                compression_next;
  run_phase_t          run;
  run_phase_t          run_next;
  logic [7:0]          previous_byte;
  logic [7:0]          previous_byte_next;
  logic [ROW_BITS-1:0] decoded;
  logic [ROW_BITS-1:0] decoded_next;
  logic [ROW_BITS-1:0] current_row;
  logic [ROW_BITS-1:0] current_row_next;

  logic                out_free;
  logic                adv;
  cmd_t                cmd;
  logic                a_emit;
  logic [7:0]          a_pixel;
  logic [7:0]          a_add;
  run_phase_t          a_run;
  logic [7:0]          a_prev;
  logic [ROW_BITS:0]   a_sum;
  logic [ROW_BITS-1:0] a_decoded;
  logic [ROW_BITS-1:0] pad_base;
  logic [ROW_BITS-1:0] width16;
  logic [ROW_BITS-1:0] pad;
  logic                res_load;
  result_t             res;

  assign cmd      = q.head;
  assign out_free = !out_valid || out_ready;
  assign adv      = q.valid && out_free;
  assign width16  = ROW_BITS'(row_width);
  assign pad_base = (step == BK_MAIN && cmd.op == CMD_ROW) ? '0 : decoded;
  assign pad      = (width16 > pad_base) ? width16 - pad_base : '0;
  assign a_sum    = (ROW_BITS + 1)'(decoded) + (ROW_BITS + 1)'(a_add);
  assign a_decoded = a_sum[ROW_BITS] ? {ROW_BITS{1'b1}} : a_sum[ROW_BITS-1:0];

  always_comb begin
    a_emit  = 1'b0;
    a_pixel = cmd.data;
    a_add   = '0;
    a_run   = run;
    a_prev  = previous_byte;
    priority if (!compression) begin
      a_emit = 1'b1;
      a_add  = 8'd1;
    end else if (run == RUN_PAIR) begin
      if (cmd.data > 8'd1) begin
        a_emit  = 1'b1;
        a_pixel = previous_byte;
        a_add   = cmd.data - 8'd1;
      end
      a_run = RUN_FRESH;
    end else if (run == RUN_HAVE && cmd.data == previous_byte && !cmd.flag) begin
      a_run = RUN_PAIR;
    end else begin
      a_emit = 1'b1;
      a_add  = 8'd1;
      a_prev = cmd.data;
      a_run  = RUN_HAVE;
    end
  end

  always_comb begin
    step_next = step;
    if (adv) begin
      unique case (step)
        BK_MAIN: begin
          if (cmd.op == CMD_DATA && cmd.flag && a_emit) begin
            step_next = BK_ROW_END;
          end
        end
        BK_ROW_END: step_next = BK_MAIN;
      endcase
    end
  end

  always_comb begin
    q_pop              = 1'b0;
    res_load           = 1'b0;
    res.kind           = KIND_ROW_END;
    res.pixel_byte     = '0;
    res.run_count      = pad;
    res.row_index      = current_row;
    res.last           = 1'b1;
    compression_next   = compression;
    run_next           = run;
    previous_byte_next = previous_byte;
    decoded_next       = decoded;
    current_row_next   = current_row;
    if (adv) begin
      if (step == BK_ROW_END) begin
        res_load         = 1'b1;
        current_row_next = current_row + ROW_BITS'(1);
        run_next         = RUN_FRESH;
        q_pop            = 1'b1;
      end else begin
        unique case (cmd.op)
          CMD_MODE: begin
            compression_next = cmd.flag;
            q_pop            = 1'b1;
          end
          CMD_SETROW: begin
            if (cmd.number > current_row) begin
              res_load      = 1'b1;
              res.kind      = KIND_BLANK;
              res.run_count = cmd.number - current_row;
            end
            current_row_next = cmd.number;
            q_pop            = 1'b1;
          end
          CMD_ROW: begin
            decoded_next = '0;
            run_next     = RUN_FRESH;
            q_pop        = 1'b1;
            if (cmd.flag) begin
              res_load         = 1'b1;
              current_row_next = current_row + ROW_BITS'(1);
            end
          end
          CMD_DATA: begin
            decoded_next       = a_decoded;
            run_next           = a_run;
            previous_byte_next = a_prev;
            if (a_emit) begin
              res_load       = 1'b1;
              res.kind       = KIND_RUN;
              res.pixel_byte = a_pixel;
              res.run_count  = ROW_BITS'(a_add);
              res.last       = !cmd.flag;
              q_pop          = !cmd.flag;
            end else if (cmd.flag) begin
              res_load         = 1'b1;
              current_row_next = current_row + ROW_BITS'(1);
              run_next         = RUN_FRESH;
              q_pop            = 1'b1;
            end else begin
              q_pop = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= BK_MAIN;
      compression   <= 1'b0;
      run           <= RUN_FRESH;
      previous_byte <= '0;
      decoded       <= '0;
      current_row   <= '0;
      out_valid     <= 1'b0;
    end else begin
      step          <= step_next;
      compression   <= compression_next;
      run           <= run_next;
      previous_byte <= previous_byte_next;
      decoded       <= decoded_next;
      current_row   <= current_row_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res;
    end
  end

  a_row_end_head: assert property (@(posedge clk) disable iff (rst)
    step == BK_ROW_END |-> q.valid && cmd.op == CMD_DATA && cmd.flag)
    else $error("row end step without a row-closing data command");

  a_row_end_beat: assert property (@(posedge clk) disable iff (rst)
    step == BK_ROW_END && adv |=> out_valid && result.kind == KIND_ROW_END && result.last)
    else $error("row end step did not produce a final row end beat");

  a_split_first: assert property (@(posedge clk) disable iff (rst)
    step == BK_MAIN && step_next == BK_ROW_END |=> result.kind == KIND_RUN && !result.last)
    else $error("first beat of a split byte is not a non-final run");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q.valid && out_free)
    else $error("pop without a queued command or free output slot");

endmodule

`default_nettype wire

/* rtl/core/raster_escape_rle_decoder.sv */
// Top level of the raster escape run-length decoder: APB register, parser,
// command queue and run back end. Depends on rerd_pkg, rerd_front, rerd_cmdq, rerd_back.
//
// One stream byte is accepted per cycle while the four-entry command queue has room; escape
// and digit bytes finish in the parser and only command and raster bytes enter the queue.
// The back end retires one queued command per cycle while its output slot is free, except
// a raster byte that both emits a run and closes its row, which yields two result beats;
// so the sustained rate is one byte per cycle and dips only at such row ends. Results leave
// through a registered output stage, so a stalled output still lets the parser run ahead
// until the queue fills. The row width register sits at byte address 0 (reset 80).
`default_nettype none

module raster_escape_rle_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic [7:0]  stream_byte,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [1:0]  kind,
  output logic [7:0]  pixel_byte,
  output logic [15:0] run_count,
  output logic [15:0] row_index,
  output logic        last,
  output logic        out_valid,
  input  logic        out_ready
);
  import rerd_pkg::*;

  logic       [9:0] row_width;
  logic             cmd_push;
  cmd_t             cmd;
  logic             q_full;
  logic             q_pop;
  cmdq_head_t       q_head;
  result_t          result;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROW_WIDTH) ? {22'b0, row_width} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROW_WIDTH) begin
      row_width <= pwdata[9:0];
    end
  end

  rerd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .stream_byte (stream_byte),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .q_full      (q_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd)
  );

  rerd_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  rerd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .row_width (row_width),
    .q         (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign kind       = result.kind;
  assign pixel_byte = result.pixel_byte;
  assign run_count  = result.run_count;
  assign row_index  = result.row_index;
  assign last       = result.last;

endmodule

`default_nettype wire

/* sim/raster_decode_checker.sv */
`timescale 1ns / 1ps
// Checker for the raster escape run-length decoder: watches the byte, descriptor and APB
// channels, predicts each descriptor and compares field by field. Depends on rerd_pkg.

module raster_decode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [7:0]  stream_byte,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  pixel_byte,
  input  logic [15:0] run_count,
  input  logic [15:0] row_index,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  output int          mismatches,
  output int          outstanding,
  output int          checked
);
  import rerd_pkg::*;

  localparam logic [2:0] ROW_WIDTH_ADDR = {REG_ROW_WIDTH, 2'b00};

  logic [9:0]   row_width;
  parse_phase_t phase;
  logic         raster_cmd;
  logic [15:0]  number;
  logic         compress;
  run_phase_t   run_state;
  logic [7:0]   held_byte;
  logic [15:0]  remaining;
  logic [15:0]  decoded;
  logic [15:0]  row;

  result_t byte_results[2];
  int      n_results;
  result_t expected_descriptors[$];

  function automatic parse_phase_t rescan(input logic [7:0] b);
    return (b == ESC_BYTE) ? PH_ESC : PH_IDLE;
  endfunction

  task automatic emit(input logic [1:0] k, input logic [7:0] p, input logic [15:0] c);
    byte_results[n_results] = '{kind: k, pixel_byte: p, run_count: c, row_index: row,
                                last: 1'b0};
    n_results++;
  endtask

  task automatic add_decoded(input logic [15:0] c);
    int unsigned s;
    s = 32'(decoded) + 32'(c);
    decoded = (s > 32'hFFFF) ? 16'hFFFF : 16'(s);
  endtask

  task automatic end_row;
    emit(KIND_ROW_END, 8'h00, (16'(row_width) > decoded) ? 16'(row_width) - decoded : 16'h0);
    row = row + 16'd1;
  endtask

  task automatic decode_stream_byte(input logic [7:0] b);
    logic        digit;
    int unsigned grown;
    n_results = 0;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    case (phase)
      PH_ESC: phase = (b == CH_STAR) ? PH_STAR : rescan(b);
      PH_STAR: begin
        if (b == CH_LOW_B || b == CH_LOW_P) begin
          raster_cmd = (b == CH_LOW_B);
          phase = PH_CMD;
        end else begin
          phase = rescan(b);
        end
      end
      PH_CMD: begin
        if (digit) begin
          number = 16'(b - CH_ZERO);
          phase = PH_DIGITS;
        end else begin
          phase = rescan(b);
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          grown = 32'(number) * 10 + 32'(b - CH_ZERO);
          number = (grown > 32'hFFFF) ? 16'hFFFF : 16'(grown);
        end else if (raster_cmd && b == CH_UP_W) begin
          remaining = number;
          decoded = 16'h0;
          run_state = RUN_FRESH;
          if (number == 16'h0) begin
            end_row();
            phase = PH_IDLE;
          end else begin
            phase = PH_RASTER;
          end
        end else if (raster_cmd && b == CH_UP_M) begin
          compress = (number != 16'h0);
          phase = PH_IDLE;
        end else if (!raster_cmd && b == CH_UP_Y) begin
          if (number > row) emit(KIND_BLANK, 8'h00, number - row);
          row = number;
          phase = PH_IDLE;
        end else begin
          phase = rescan(b);
        end
      end
      PH_RASTER: begin
        remaining = remaining - 16'd1;
        if (!compress) begin
          emit(KIND_RUN, b, 16'd1);
          add_decoded(16'd1);
        end else if (run_state == RUN_PAIR) begin
          if (b > 8'd1) begin
            emit(KIND_RUN, held_byte, 16'(b) - 16'd1);
            add_decoded(16'(b) - 16'd1);
          end
          run_state = RUN_FRESH;
        end else if (run_state == RUN_HAVE && b == held_byte && remaining != 16'h0) begin
          run_state = RUN_PAIR;
        end else begin
          emit(KIND_RUN, b, 16'd1);
          add_decoded(16'd1);
          held_byte = b;
          run_state = RUN_HAVE;
        end
        if (remaining == 16'h0) begin
          end_row();
          run_state = RUN_FRESH;
          phase = PH_IDLE;
        end
      end
      default: phase = rescan(b);
    endcase
    if (n_results > 0) byte_results[n_results - 1].last = 1'b1;
    for (int i = 0; i < n_results; i++) expected_descriptors.push_back(byte_results[i]);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  task automatic check_descriptor;
    result_t want;
    if (expected_descriptors.size() == 0) begin
      mismatches++;
      $display("%0t: descriptor expected none, got kind %0d byte %0d count %0d row %0d last %0d",
               $time, kind, pixel_byte, run_count, row_index, last);
      return;
    end
    want = expected_descriptors.pop_front();
    check_field("kind", 32'(want.kind), 32'(kind));
    check_field("pixel_byte", 32'(want.pixel_byte), 32'(pixel_byte));
    check_field("run_count", 32'(want.run_count), 32'(run_count));
    check_field("row_index", 32'(want.row_index), 32'(row_index));
    check_field("last", 32'(want.last), 32'(last));
    checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      row_width = ROW_WIDTH_RESET;
      phase = PH_IDLE;
      raster_cmd = 1'b0;
      number = 16'h0;
      compress = 1'b0;
      run_state = RUN_FRESH;
      held_byte = 8'h00;
      remaining = 16'h0;
      decoded = 16'h0;
      row = 16'h0;
      expected_descriptors.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ROW_WIDTH_ADDR)
        row_width = pwdata[9:0];
      if (in_valid && in_ready) decode_stream_byte(stream_byte);
      if (out_valid && out_ready) check_descriptor();
    end
    outstanding = expected_descriptors.size();
  end

endmodule

/* sim/raster_escape_rle_decoder_test.sv */
`timescale 1ns / 1ps
// Top of the decoder testbench: clock, reset, byte stream and APB stimulus, descriptor
// back pressure and verdict. Depends on rerd_pkg, raster_decode_checker and the decoder RTL.

module raster_escape_rle_decoder_test;
  import rerd_pkg::*;

  localparam int         STALL_LIMIT    = 2000;
  localparam int         DRAIN_CYCLES   = 12;
  localparam int         LONG_STALL     = 240;
  localparam logic [2:0] ROW_WIDTH_ADDR = {REG_ROW_WIDTH, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [7:0]  stream_byte = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind;
  logic [7:0]  pixel_byte;
  logic [15:0] run_count;
  logic [15:0] row_index;
  logic        last;
  logic        out_valid;
  logic        out_ready = 1'b0;

  int mismatches;
  int outstanding;
  int checked;
  int bytes_sent = 0;
  int noise_bytes = 0;
  int width_writes = 0;
  int quiet_cycles = 0;
  int stall_requests = 0;
  int stall_served = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;

  raster_escape_rle_decoder DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .stream_byte(stream_byte), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .pixel_byte(pixel_byte), .run_count(run_count), .row_index(row_index),
    .last(last), .out_valid(out_valid), .out_ready(out_ready)
  );

  raster_decode_checker decode_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata),
    .stream_byte(stream_byte), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .pixel_byte(pixel_byte), .run_count(run_count), .row_index(row_index),
    .last(last), .out_valid(out_valid), .out_ready(out_ready),
    .mismatches(mismatches), .outstanding(outstanding), .checked(checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d descriptors outstanding",
               $time, quiet_cycles, outstanding);
      $display("raster_escape_rle_decoder_test: done, errors");
      $finish;
    end
  end

  initial begin
    int span;
    @(negedge rst);
    forever begin
      if (stall_served != stall_requests) begin
        stall_served++;
        out_ready <= 1'b0;
        span = LONG_STALL;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 6);
      end
      repeat (span) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    stream_byte <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_number(input int unsigned n);
    logic [7:0] digits[$];
    if ($urandom_range(0, 7) == 0) send_byte(CH_ZERO);
    do begin
      digits.push_front(CH_ZERO + 8'(n % 10));
      n = n / 10;
    end while (n != 0);
    foreach (digits[i]) send_byte(digits[i]);
  endtask

  task automatic send_command(input logic [7:0] grp, input int unsigned n,
                              input logic [7:0] term);
    send_byte(ESC_BYTE);
    send_byte(CH_STAR);
    send_byte(grp);
    send_number(n);
    send_byte(term);
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return ESC_BYTE;
      3: return 8'h55;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mix literal bytes with byte, byte, count triples; the row length cuts them anywhere
  task automatic send_row(input int unsigned len);
    logic [7:0]  b;
    int unsigned sent;
    send_command(CH_LOW_B, len, CH_UP_W);
    sent = 0;
    while (sent < len) begin
      b = pick_pixel();
      send_byte(b);
      sent++;
      if (sent < len && $urandom_range(0, 9) < 4) begin
        send_byte(b);
        sent++;
        if (sent < len) begin
          send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
  endtask

  task automatic send_noise;
    int         first;
    logic [7:0] b;
    logic [7:0] grp;
    logic [7:0] term;
    first = bytes_sent;
    grp = ($urandom_range(0, 1) == 0) ? CH_LOW_B : CH_LOW_P;
    case ($urandom_range(0, 2))
      0: begin
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom_range(0, 255));
          if (b >= CH_ZERO && b <= CH_NINE) b = ESC_BYTE;
          send_byte(b);
        end
      end
      1: begin
        case ($urandom_range(0, 2))
          0: term = ESC_BYTE;
          1: term = CH_STAR;
          default: term = (grp == CH_LOW_B) ? CH_UP_Y : CH_UP_W;
        endcase
        send_command(grp, $urandom_range(0, 99), term);
      end
      default: begin
        send_byte(ESC_BYTE);
        if ($urandom_range(0, 1) == 0) begin
          send_byte(CH_STAR);
          if ($urandom_range(0, 1) == 0) send_byte(grp);
        end
      end
    endcase
    noise_bytes += bytes_sent - first;
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_width(input logic [9:0] w);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ROW_WIDTH_ADDR;
    pwdata <= {22'($urandom), w};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    width_writes++;
  endtask

  initial begin
    logic [7:0]  b;
    int unsigned mark;
    int unsigned last_write;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero-length row at reset width, raw data with extremes and ESC inside the row
    send_command(CH_LOW_B, 0, CH_UP_W);
    send_command(CH_LOW_B, 3, CH_UP_W);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ESC_BYTE);
    // failed escapes: ESC restarts, wrong terminator, ESC after digits
    send_byte(ESC_BYTE);
    send_command(CH_LOW_P, 5, CH_UP_Y);
    send_byte(ESC_BYTE);
    send_byte(CH_STAR);
    send_byte(CH_LOW_B);
    send_byte(CH_ZERO);
    send_byte(CH_UP_Y);
    send_byte(ESC_BYTE);
    send_byte(CH_STAR);
    send_byte(CH_LOW_P);
    send_byte(CH_ZERO + 8'd1);
    send_byte(ESC_BYTE);
    send_byte(CH_STAR);
    send_byte(CH_LOW_P);
    send_byte(CH_ZERO);
    send_byte(CH_UP_Y);
    // compressed: repeat, pair at row end, counts zero and one
    send_command(CH_LOW_B, 99999, CH_UP_M);
    send_command(CH_LOW_B, 5, CH_UP_W);
    send_byte(8'h07);
    send_byte(8'h07);
    send_byte(8'h05);
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_command(CH_LOW_B, 6, CH_UP_W);
    send_byte(8'h03);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h04);
    send_byte(8'h04);
    send_byte(8'h01);
    send_command(CH_LOW_B, 0, CH_UP_M);
    // saturated row number, row counter wrap
    send_command(CH_LOW_P, 99999, CH_UP_Y);
    send_command(CH_LOW_B, 0, CH_UP_W);
    write_row_width(10'd1);
    send_command(CH_LOW_B, 2, CH_UP_W);
    send_byte(8'h55);
    send_byte(8'hAA);
    write_row_width(10'd1023);
    send_command(CH_LOW_B, 0, CH_UP_W);

    // hold the descriptor side while bytes keep coming
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    stall_requests++;
    send_command(CH_LOW_B, 40, CH_UP_W);
    repeat (40) send_byte(8'($urandom_range(0, 255)));
    wait_drained();

    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    mark = bytes_sent - noise_bytes;
    last_write = bytes_sent;
    while (bytes_sent - noise_bytes - mark < 220) begin
      if (bytes_sent - last_write >= 100) begin
        case (width_writes % 4)
          0: write_row_width(10'd1);
          1: write_row_width(10'd1023);
          2: write_row_width(10'($urandom_range(2, 12)));
          default: write_row_width(10'($urandom_range(1, 1023)));
        endcase
        last_write = bytes_sent;
      end
      if ($urandom_range(0, 7) == 0) begin
        sender_idles = 1'($urandom_range(0, 1));
        receiver_idles = 1'($urandom_range(0, 1));
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
          send_row(($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16));
        10, 11, 12:
          send_command(CH_LOW_B, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 300)
                                                             : $urandom_range(0, 1), CH_UP_M);
        13, 14:
          send_command(CH_LOW_P, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 999999)
                                                             : $urandom_range(0, 40), CH_UP_Y);
        default: send_noise();
      endcase
    end

    // compressed row whose last byte carries both a long run and the row end
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    send_command(CH_LOW_B, 1, CH_UP_M);
    send_command(CH_LOW_B, 3, CH_UP_W);
    b = pick_pixel();
    send_byte(b);
    send_byte(b);
    send_byte(8'hFF);

    mark = bytes_sent;
    while (bytes_sent - mark < 70) begin
      if ($urandom_range(0, 3) == 0) begin
        send_command(CH_LOW_B, $urandom_range(0, 1), CH_UP_M);
      end else begin
        send_row($urandom_range(0, 12));
      end
    end

    wait_drained();
    $display("%0d stream bytes (%0d noise), %0d descriptors checked, %0d row width writes",
             bytes_sent, noise_bytes, checked, width_writes);
    $display("%0d mismatches, %0d descriptors never seen", mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("raster_escape_rle_decoder_test: done, clean");
    end else begin
      $display("raster_escape_rle_decoder_test: done, errors");
    end
    $finish;
  end

endmodule
